FILE: hw/rtl/red_pkg.sv
// ----------------------------------------------------------------------------
// red_pkg: shared types and constants for the rotary encoder block
// Commands, register indexes, the quadrature step table and the structs
// passed between the encoder, button and configuration units.
// ----------------------------------------------------------------------------
package red_pkg;

  localparam int TIME_BITS = 32;
  localparam int CMD_W     = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int COUNT_W   = 8;
  localparam int DETENT_W  = 6;

  localparam logic [CFG_DAT_W-1:0] DEBOUNCE_RESET = 16'd150;
  localparam logic [CFG_DAT_W-1:0] HOLD_RESET     = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_SYNC        = 3'd0,
    CMD_AB_CHANGE   = 3'd1,
    CMD_BTN_EDGE    = 3'd2,
    CMD_TICK        = 3'd3,
    CMD_READ_DETENT = 3'd4,
    CMD_READ_PRESS  = 3'd5,
    CMD_POLL_HOLD   = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 1'b0,
    REG_HOLD     = 1'b1
  } reg_idx_t;

  // Indexed by {previous A, previous B, current A, current B}.
  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  typedef struct packed {
    logic             fire;
    logic [CMD_W-1:0] command;
  } step_ctl_t;

  typedef struct packed {
    logic [CFG_DAT_W-1:0] debounce_time;
    logic [CFG_DAT_W-1:0] hold_time;
  } cfg_regs_t;

  typedef struct packed {
    logic press_event;
    logic hold_event;
    logic button_down;
  } btn_res_t;

endpackage

FILE: hw/rtl/red_in_if.sv
// ----------------------------------------------------------------------------
// red_in_if: input item channel
// Valid/ready channel carrying one command with encoder levels and edges.
// ----------------------------------------------------------------------------
interface red_in_if;
  import red_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic             level_a;
  logic             level_b;
  logic             falling_edge;
  logic             rising_edge;

  modport source (output valid, command, level_a, level_b, falling_edge, rising_edge,
                  input ready);
  modport sink (input valid, command, level_a, level_b, falling_edge, rising_edge,
                output ready);
endinterface

FILE: hw/rtl/red_out_if.sv
// ----------------------------------------------------------------------------
// red_out_if: result channel
// Valid/ready channel carrying detents, button events and button state.
// ----------------------------------------------------------------------------
interface red_out_if;
  import red_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [DETENT_W-1:0] detent_steps;
  logic                       press_event;
  logic                       hold_event;
  logic                       button_down;

  modport source (output valid, detent_steps, press_event, hold_event, button_down,
                  input ready);
  modport sink (input valid, detent_steps, press_event, hold_event, button_down,
                output ready);
endinterface

FILE: hw/rtl/red_cfg_if.sv
// ----------------------------------------------------------------------------
// red_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface red_cfg_if;
  import red_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rotary_encoder_with_button.sv
// ----------------------------------------------------------------------------
// rotary_encoder_with_button: quadrature encoder and push button decoder
// Input register, single-pass command logic and result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries one command per transfer: sync A/B, A/B change, button
//           edge, millisecond tick, read detents, read press or poll hold,
//           with the sampled A/B levels and the press/release edge flags.
//   out_ch  returns exactly one result per command: whole detents on a read,
//           the pending short press, a one-shot hold event and the debounced
//           button state after the command.
//   cfg_ch  writes debounce_time (index 0) and hold_time (index 1); always
//           ready. Write only while no command is in flight.
// The input register takes the command at the transfer edge; the command
// logic then loads the result register once that register is empty or
// drains, and the result shows on out_ch. Throughput is one command per
// cycle while the receiver does not stall, set by the single pass through
// the encoder and button units.
// When the receiver stalls, the result register holds and the input register
// still takes one more command, after which in_ch.ready drops.
// Reset clears both pipeline stages, the count, the time base and all flags,
// and loads the configuration defaults (150 and 1000 ms).
// ----------------------------------------------------------------------------
module rotary_encoder_with_button (
  input  logic     clk,
  input  logic     rst_n,
  red_in_if.sink   in_ch,
  red_out_if.source out_ch,
  red_cfg_if.sink  cfg_ch
);
  import red_pkg::*;

  // Input register
  logic             in_valid_r, in_valid_nxt;
  logic [CMD_W-1:0] in_cmd_r;
  logic             in_a_r;
  logic             in_b_r;
  logic             in_fall_r;
  logic             in_rise_r;

  // Result register
  logic                       out_valid_r, out_valid_nxt;
  logic signed [DETENT_W-1:0] out_detent_r;
  btn_res_t                   out_btn_r;

  logic                       in_take;
  logic                       advance;
  step_ctl_t                  ctl;
  cfg_regs_t                  regs;
  logic signed [DETENT_W-1:0] detent_steps;
  btn_res_t                   btn_res;

  // Advance the input stage whenever the result register is empty or drains.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign ctl.fire    = advance;
  assign ctl.command = in_cmd_r;

  red_cfg_regs u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg_ch(cfg_ch),
    .regs  (regs)
  );

  red_encoder u_enc (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .level_a     (in_a_r),
    .level_b     (in_b_r),
    .detent_steps(detent_steps)
  );

  red_button u_btn (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .falling_edge(in_fall_r),
    .rising_edge (in_rise_r),
    .regs        (regs),
    .res         (btn_res)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take)      in_valid_nxt = 1'b1;
    else if (advance) in_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (advance)           out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the command payload on an input transfer.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_cmd_r  <= in_ch.command;
      in_a_r    <= in_ch.level_a;
      in_b_r    <= in_ch.level_b;
      in_fall_r <= in_ch.falling_edge;
      in_rise_r <= in_ch.rising_edge;
    end
  end

  // Load the result as the command commits its state update.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_detent_r <= detent_steps;
      out_btn_r    <= btn_res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.detent_steps = out_detent_r;
  assign out_ch.press_event  = out_btn_r.press_event;
  assign out_ch.hold_event   = out_btn_r.hold_event;
  assign out_ch.button_down  = out_btn_r.button_down;

  // A hold is only reported while the button is down.
  a_hold_implies_down: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_btn_r.hold_event |-> out_btn_r.button_down)
    else $error("hold event reported with button up");

  // Only a detent read produces nonzero detents.
  a_detent_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_cmd_r != CMD_READ_DETENT) |=> (out_detent_r == '0))
    else $error("nonzero detents from a non-read command");

  // A single command never raises both a press and a hold event.
  a_events_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_btn_r.press_event && out_btn_r.hold_event))
    else $error("press and hold events in one result");

  // A waiting command stays in the input register until it advances.
  a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_cmd_r))
    else $error("input register lost a waiting command");
endmodule

FILE: hw/rtl/red_cfg_regs.sv
// ----------------------------------------------------------------------------
// red_cfg_regs: configuration registers
// Holds debounce and hold times; every write transfer is taken at once.
// ----------------------------------------------------------------------------
module red_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  red_cfg_if.sink            cfg_ch,
  output red_pkg::cfg_regs_t regs
);
  import red_pkg::*;

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_DEBOUNCE: regs_nxt.debounce_time = cfg_ch.data;
        REG_HOLD:     regs_nxt.hold_time     = cfg_ch.data;
        default:      regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.debounce_time <= DEBOUNCE_RESET;
      regs_r.hold_time     <= HOLD_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end
endmodule

FILE: hw/rtl/red_encoder.sv
// ----------------------------------------------------------------------------
// red_encoder: quadrature decode and detent counter
// Tracks the previous A/B code, keeps a saturating pulse count and hands
// out whole detents on a read, keeping the remainder.
// ----------------------------------------------------------------------------
module red_encoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  red_pkg::step_ctl_t                  ctl,
  input  logic                                level_a,
  input  logic                                level_b,
  output logic signed [red_pkg::DETENT_W-1:0] detent_steps
);
  import red_pkg::*;

  logic        [1:0]         prev_ab_r, prev_ab_nxt;
  logic signed [COUNT_W-1:0] count_r, count_nxt;
  logic        [1:0]         ab;
  logic signed [1:0]         delta;
  logic signed [COUNT_W:0]   sum;
  logic signed [COUNT_W-1:0] biased;
  logic signed [DETENT_W-1:0] steps;

  assign ab    = {level_a, level_b};
  assign delta = STEP_TABLE[{prev_ab_r, ab}];
  assign sum   = {count_r[COUNT_W-1], count_r} + {{(COUNT_W-1){delta[1]}}, delta};

  // Round toward zero: bias negative counts by 3 before the arithmetic shift.
  assign biased = count_r + (count_r[COUNT_W-1] ? COUNT_W'(3) : COUNT_W'(0));
  assign steps  = biased[COUNT_W-1:2];

  always_comb begin
    prev_ab_nxt  = prev_ab_r;
    count_nxt    = count_r;
    detent_steps = '0;
    case (ctl.command)
      CMD_SYNC: prev_ab_nxt = ab;
      CMD_AB_CHANGE: begin
        prev_ab_nxt = ab;
        if (sum > 9'sd127)       count_nxt = 8'sd127;
        else if (sum < -9'sd128) count_nxt = -8'sd128;
        else                     count_nxt = sum[COUNT_W-1:0];
      end
      CMD_READ_DETENT: begin
        detent_steps = steps;
        count_nxt    = count_r - {steps, 2'b00};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r <= '0;
      count_r   <= '0;
    end else if (ctl.fire) begin
      prev_ab_r <= prev_ab_nxt;
      count_r   <= count_nxt;
    end
  end
endmodule

FILE: hw/rtl/red_button.sv
// ----------------------------------------------------------------------------
// red_button: button debounce, press and hold tracking
// Keeps the millisecond time base, debounces edges, latches short presses
// and reports a hold once per press.
// ----------------------------------------------------------------------------
module red_button (
  input  logic               clk,
  input  logic               rst_n,
  input  red_pkg::step_ctl_t ctl,
  input  logic               falling_edge,
  input  logic               rising_edge,
  input  red_pkg::cfg_regs_t regs,
  output red_pkg::btn_res_t  res
);
  import red_pkg::*;

  logic [TIME_BITS-1:0] time_r, time_nxt;
  logic [TIME_BITS-1:0] last_edge_r, last_edge_nxt;
  logic [TIME_BITS-1:0] press_start_r, press_start_nxt;
  logic                 pressed_r, pressed_nxt;
  logic                 held_r, held_nxt;
  logic                 pending_r, pending_nxt;
  logic [TIME_BITS-1:0] since_edge;
  logic [TIME_BITS-1:0] since_press;
  logic                 debounce_ok;
  logic                 hold_over;

  assign since_edge  = time_r - last_edge_r;
  assign since_press = time_r - press_start_r;
  assign debounce_ok = since_edge > TIME_BITS'(regs.debounce_time);
  assign hold_over   = since_press > TIME_BITS'(regs.hold_time);

  always_comb begin
    time_nxt        = time_r;
    last_edge_nxt   = last_edge_r;
    press_start_nxt = press_start_r;
    pressed_nxt     = pressed_r;
    held_nxt        = held_r;
    pending_nxt     = pending_r;
    res             = '0;
    case (ctl.command)
      CMD_BTN_EDGE: begin
        if (debounce_ok) begin
          last_edge_nxt = time_r;
          if (falling_edge) begin
            pressed_nxt     = 1'b1;
            press_start_nxt = time_r;
            held_nxt        = 1'b0;
          end else if (rising_edge) begin
            pressed_nxt = 1'b0;
            if (!held_r) pending_nxt = 1'b1;
          end
        end
      end
      CMD_TICK: time_nxt = time_r + TIME_BITS'(1);
      CMD_READ_PRESS: begin
        res.press_event = pending_r;
        pending_nxt     = 1'b0;
      end
      CMD_POLL_HOLD: begin
        if (pressed_r && !held_r && hold_over) begin
          held_nxt       = 1'b1;
          res.hold_event = 1'b1;
        end
      end
      default: ;
    endcase
    res.button_down = pressed_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r        <= '0;
      last_edge_r   <= '0;
      press_start_r <= '0;
      pressed_r     <= 1'b0;
      held_r        <= 1'b0;
      pending_r     <= 1'b0;
    end else if (ctl.fire) begin
      time_r        <= time_nxt;
      last_edge_r   <= last_edge_nxt;
      press_start_r <= press_start_nxt;
      pressed_r     <= pressed_nxt;
      held_r        <= held_nxt;
      pending_r     <= pending_nxt;
    end
  end
endmodule
